>>> rtl/assert_macros.svh
// Assertion macros shared by the update sequencer RTL.
// No dependencies; included inside module bodies that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at each rising clock edge, skipped while reset is held.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Condition that must never be true at a rising clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

>>> rtl/fus_pkg.sv
// Package for the flash update sequencer: codes, command and result types,
// CRC-32/BZIP2 byte table. No dependencies.
package fus_pkg;

    // CRC-32/BZIP2 constants
    localparam logic [31:0] CRC_POLY     = 32'h04C1_1DB7;
    localparam logic [31:0] ALL_ONES     = 32'hFFFF_FFFF;
    localparam logic [15:0] FLAG_PENDING = 16'h5651;
    localparam logic [15:0] FLAG_OTHER   = 16'hAAAA;
    localparam logic [31:0] CHUNK_BYTES  = 32'd8;

    // Register reset values
    localparam logic [7:0]  RST_START_CMD  = 8'd1;
    localparam logic [31:0] RST_APP_START  = 32'd0;
    localparam logic [31:0] RST_APP_END    = 32'hFFFF_FFFF;
    localparam logic [31:0] RST_APP_REGION = 32'd0;

    // Default depth of the command queue between front and back
    localparam int FIFO_DEPTH_DEF = 4;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_START_CMD  = 2'd0,
        CFG_APP_START  = 2'd1,
        CFG_APP_END    = 2'd2,
        CFG_APP_REGION = 2'd3
    } t_cfg_idx;

    // Update sequence phase
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_SIZE = 2'd1,
        PH_DATA = 2'd2,
        PH_CRC  = 2'd3
    } t_phase;

    // Result action codes
    typedef enum logic [2:0] {
        ACT_ERASE = 3'd0,
        ACT_FLAGS = 3'd1,
        ACT_WRITE = 3'd2,
        ACT_RESP  = 3'd3,
        ACT_RESET = 3'd4
    } t_action;

    // Response codes
    typedef enum logic [1:0] {
        RESP_BIN  = 2'd0,
        RESP_WERR = 2'd1,
        RESP_ADDR = 2'd2,
        RESP_DONE = 2'd3
    } t_resp;

    // Command kinds queued by the front for the back
    typedef enum logic [2:0] {
        CMD_START   = 3'd0,
        CMD_WRITE   = 3'd1,
        CMD_RXFAIL  = 3'd2,
        CMD_ADDRERR = 3'd3,
        CMD_DONE    = 3'd4,
        CMD_WERR    = 3'd5
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind   kind;
        logic [31:0] addr;
        logic [31:0] lo;
        logic [31:0] hi;
    } t_cmd;

    // Control from the front to the CRC unit
    typedef struct packed {
        logic start;   // fold a new 8-byte chunk
        logic init;    // reload all ones
    } t_crc_ctl;

    typedef struct packed {
        t_action     action;
        logic [31:0] flash_addr;
        logic [31:0] word_low;
        logic [31:0] word_high;
        t_resp       response_code;
        logic [15:0] boot_flag;
        logic [15:0] app_status;
    } t_result;

    // Byte-wise table, worked out at elaboration
    typedef logic [255:0][31:0] t_crc_tab;

    function automatic t_crc_tab gen_crc_tab();
        t_crc_tab    tab;
        logic [31:0] c;
        for (int i = 0; i < 256; i++) begin
            c = {i[7:0], 24'd0};
            for (int k = 0; k < 8; k++) begin
                c = c[31] ? ({c[30:0], 1'b0} ^ CRC_POLY) : {c[30:0], 1'b0};
            end
            tab[i] = c;
        end
        return tab;
    endfunction

    localparam t_crc_tab CRC_TAB = gen_crc_tab();

endpackage

>>> rtl/fus_crc.sv
// CRC-32/BZIP2 unit: folds an 8-byte chunk two bytes per cycle.
// Depends on fus_pkg (table, control struct).
module fus_crc (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fus_pkg::t_crc_ctl  i_ctl,
    input  logic [63:0]        i_data,
    output logic               o_busy,
    output logic [31:0]        o_crc
);
    import fus_pkg::*;

    logic [31:0] r_crc;
    logic [63:0] r_data;
    logic [1:0]  r_cnt;
    logic        r_busy;
    logic [31:0] w_c1;
    logic [31:0] w_c2;

    // two table steps per cycle, lowest byte first
    assign w_c1 = {r_crc[23:0], 8'd0} ^ CRC_TAB[r_crc[31:24] ^ r_data[7:0]];
    assign w_c2 = {w_c1[23:0], 8'd0} ^ CRC_TAB[w_c1[31:24] ^ r_data[15:8]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc  <= ALL_ONES;
            r_busy <= 1'b0;
            r_cnt  <= 2'd0;
        end else if (i_ctl.init) begin
            r_crc  <= ALL_ONES;
            r_busy <= 1'b0;
            r_cnt  <= 2'd0;
        end else if (i_ctl.start) begin
            r_busy <= 1'b1;
            r_cnt  <= 2'd0;
        end else if (r_busy) begin
            r_crc <= w_c2;
            r_cnt <= r_cnt + 2'd1;
            if (r_cnt == 2'd3) begin
                r_busy <= 1'b0;
            end
        end
    end

    // chunk shift register
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_data <= i_data;
        end else if (r_busy) begin
            r_data <= {16'd0, r_data[63:16]};
        end
    end

    assign o_busy = r_busy;
    assign o_crc  = r_crc;

    `include "assert_macros.svh"

    `ASSERT_NEVER(a_crc_start_busy, i_ctl.start && r_busy, "CRC start while busy")
    `ASSERT_CLK(a_crc_runs_four, $rose(r_busy) |=> ##2 r_busy, "CRC pass shorter than 4")

endmodule

>>> rtl/fus_front.sv
// Front part: accepts frames, runs the update phase machine, queues commands.
// Depends on fus_pkg; drives fus_crc and the command queue.
module fus_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_ok,
    input  logic [31:0]        i_lo,
    input  logic [31:0]        i_hi,
    input  logic [7:0]         i_start_cmd,
    input  logic [31:0]        i_app_start,
    input  logic [31:0]        i_app_end,
    input  logic [31:0]        i_app_region,
    input  logic               i_fifo_full,
    input  logic               i_crc_busy,
    input  logic [31:0]        i_crc,
    output logic               o_push,
    output fus_pkg::t_cmd      o_cmd,
    output fus_pkg::t_crc_ctl  o_crc_ctl
);
    import fus_pkg::*;

    t_phase      r_phase, n_phase;
    logic [31:0] r_image_size, n_image_size;
    logic [31:0] r_bytes_done, n_bytes_done;
    logic [31:0] r_reset_vec, n_reset_vec;
    logic        r_wrote_any, n_wrote_any;

    logic        w_fire;
    logic        w_is_start;
    logic        w_crc_match;
    logic        w_vec_ok;
    logic [31:0] w_bytes_next;
    logic        w_clear;

    assign o_ready      = !i_crc_busy && !i_fifo_full;
    assign w_fire       = i_valid && o_ready;
    assign w_is_start   = (i_lo[7:0] == i_start_cmd);
    assign w_crc_match  = ((i_crc ^ ALL_ONES) == i_lo);
    assign w_vec_ok     = !(r_reset_vec < i_app_start) && !(r_reset_vec > i_app_end);
    assign w_bytes_next = r_bytes_done + CHUNK_BYTES;
    // back to reset values after a receive failure or a finished update
    assign w_clear = w_fire && (((r_phase == PH_DATA) && !i_ok) ||
                                ((r_phase == PH_CRC) && w_crc_match && w_vec_ok));

    // next state
    always_comb begin
        n_phase      = r_phase;
        n_image_size = r_image_size;
        n_bytes_done = r_bytes_done;
        n_reset_vec  = r_reset_vec;
        n_wrote_any  = r_wrote_any;
        if (w_fire) begin
            case (r_phase)
                PH_IDLE: begin
                    if (w_is_start) begin
                        n_bytes_done = '0;
                        n_reset_vec  = ALL_ONES;
                        n_phase      = PH_SIZE;
                    end
                end
                PH_SIZE: begin
                    n_image_size = i_lo;
                    n_phase      = (r_bytes_done < i_lo) ? PH_DATA : PH_CRC;
                end
                PH_DATA: begin
                    if (i_ok) begin
                        if (r_bytes_done == '0) begin
                            n_reset_vec = i_hi;
                        end
                        n_bytes_done = w_bytes_next;
                        n_wrote_any  = 1'b1;
                        if (!(w_bytes_next < r_image_size)) begin
                            n_phase = PH_CRC;
                        end
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
            if (w_clear) begin
                n_phase      = PH_IDLE;
                n_image_size = '0;
                n_bytes_done = '0;
                n_reset_vec  = ALL_ONES;
                n_wrote_any  = 1'b0;
            end
        end
    end

    // outputs: queued command and CRC control
    always_comb begin
        o_push          = 1'b0;
        o_cmd.kind      = CMD_WRITE;
        o_cmd.addr      = i_app_start + r_bytes_done;
        o_cmd.lo        = i_lo;
        o_cmd.hi        = i_hi;
        o_crc_ctl.start = 1'b0;
        o_crc_ctl.init  = w_clear;
        if (w_fire) begin
            case (r_phase)
                PH_IDLE: begin
                    if (w_is_start) begin
                        o_push         = 1'b1;
                        o_cmd.kind     = CMD_START;
                        o_cmd.addr     = i_app_start;
                        o_cmd.lo       = i_app_region;
                        o_crc_ctl.init = 1'b1;
                    end
                end
                PH_SIZE: begin
                    o_push = 1'b0;
                end
                PH_DATA: begin
                    o_push = 1'b1;
                    if (i_ok) begin
                        o_crc_ctl.start = 1'b1;
                    end else begin
                        o_cmd.kind = CMD_RXFAIL;
                    end
                end
                default: begin
                    if (w_crc_match) begin
                        o_push     = 1'b1;
                        o_cmd.kind = w_vec_ok ? CMD_DONE : CMD_ADDRERR;
                    end else if (r_wrote_any) begin
                        o_push     = 1'b1;
                        o_cmd.kind = CMD_WERR;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_image_size <= '0;
            r_bytes_done <= '0;
            r_reset_vec  <= ALL_ONES;
            r_wrote_any  <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_image_size <= n_image_size;
            r_bytes_done <= n_bytes_done;
            r_reset_vec  <= n_reset_vec;
            r_wrote_any  <= n_wrote_any;
        end
    end

    `include "assert_macros.svh"

    `ASSERT_CLK(a_chunk_starts_crc, (w_fire && (r_phase == PH_DATA) && i_ok) |=> i_crc_busy,
        "accepted chunk did not start the CRC unit")
    `ASSERT_CLK(a_clear_to_idle, w_clear |=> (r_phase == PH_IDLE) && !r_wrote_any,
        "clear did not return to idle")

endmodule

>>> rtl/fus_fifo.sv
// Short command queue between the front and the back.
// Depends on fus_pkg (command type).
module fus_fifo #(
    parameter int DEPTH = fus_pkg::FIFO_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  fus_pkg::t_cmd  i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output fus_pkg::t_cmd  o_head
);
    import fus_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd        r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    `include "assert_macros.svh"

    `ASSERT_NEVER(a_fifo_overflow, i_push && o_full, "push into full queue")
    `ASSERT_NEVER(a_fifo_underflow, i_pop && o_empty, "pop from empty queue")

endmodule

>>> rtl/fus_back.sv
// Back part: expands each queued command into one to three results and
// holds them in an output register. Depends on fus_pkg.
module fus_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_empty,
    input  fus_pkg::t_cmd      i_head,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output fus_pkg::t_result   o_result,
    output logic               o_last
);
    import fus_pkg::*;

    logic [1:0] r_idx;
    logic       r_valid;
    t_result    r_result;
    logic       r_last;
    t_result    w_res;
    logic [1:0] w_last_idx;
    logic       w_load;
    logic       w_is_last;

    // index of the final result of each command
    always_comb begin
        case (i_head.kind)
            CMD_START, CMD_RXFAIL, CMD_DONE: w_last_idx = 2'd2;
            default:                         w_last_idx = 2'd0;
        endcase
    end

    // result for the current command and index
    always_comb begin
        w_res.action        = ACT_RESP;
        w_res.flash_addr    = '0;
        w_res.word_low      = '0;
        w_res.word_high     = '0;
        w_res.response_code = RESP_BIN;
        w_res.boot_flag     = '0;
        w_res.app_status    = '0;
        case (i_head.kind)
            CMD_START: begin
                case (r_idx)
                    2'd0: begin
                        w_res.action     = ACT_ERASE;
                        w_res.flash_addr = i_head.addr;
                        w_res.word_low   = i_head.lo;
                    end
                    2'd1: begin
                        w_res.action     = ACT_FLAGS;
                        w_res.boot_flag  = FLAG_PENDING;
                        w_res.app_status = FLAG_OTHER;
                    end
                    default: w_res.response_code = RESP_BIN;
                endcase
            end
            CMD_WRITE: begin
                w_res.action     = ACT_WRITE;
                w_res.flash_addr = i_head.addr;
                w_res.word_low   = i_head.lo;
                w_res.word_high  = i_head.hi;
            end
            CMD_RXFAIL: begin
                case (r_idx)
                    2'd0: w_res.response_code = RESP_WERR;
                    2'd1: begin
                        w_res.action     = ACT_FLAGS;
                        w_res.boot_flag  = FLAG_PENDING;
                        w_res.app_status = FLAG_OTHER;
                    end
                    default: w_res.action = ACT_RESET;
                endcase
            end
            CMD_ADDRERR: w_res.response_code = RESP_ADDR;
            CMD_DONE: begin
                case (r_idx)
                    2'd0: w_res.response_code = RESP_DONE;
                    2'd1: begin
                        w_res.action     = ACT_FLAGS;
                        w_res.boot_flag  = FLAG_OTHER;
                        w_res.app_status = FLAG_PENDING;
                    end
                    default: w_res.action = ACT_RESET;
                endcase
            end
            default: w_res.response_code = RESP_WERR;
        endcase
    end

    assign w_load    = !i_empty && (!r_valid || i_ready);
    assign w_is_last = (r_idx == w_last_idx);
    assign o_pop     = w_load && w_is_last;

    // result index and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_idx   <= w_is_last ? 2'd0 : r_idx + 2'd1;
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_result <= w_res;
            r_last   <= w_is_last;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;
    assign o_last   = r_last;

    `include "assert_macros.svh"

    `ASSERT_NEVER(a_idx_range, r_idx == 2'd3, "result index out of range")

endmodule

>>> rtl/flash_update_sequencer_crc32_top.sv
// Top level of the flash update sequencer with on-the-fly CRC-32/BZIP2.
// Depends on fus_pkg, fus_front, fus_crc, fus_fifo and fus_back.
//
// Takes one received 8-byte frame per transaction and drives a firmware
// update: start command (erase, store flags, request binary), size frame,
// 8-byte data chunks (flash writes folded into CRC-32/BZIP2), then a CRC
// frame followed by a reset vector bounds check. A command frame, size
// frame or CRC frame does not close the input; a data chunk closes it while
// the CRC unit folds it, two bytes per cycle through a 256-entry table.
// Each frame that causes results queues one command into a FIFO_DEPTH-entry
// queue, and the input also closes while that queue is full; the back end
// turns each command into 1 to 3 results, one per cycle unless the output
// stalls, held in an output register, so input and output stall on their
// own. The user must write configuration through the plain write port only
// while idle (the block does not enforce it); there is no clearing pass after reset.
module flash_update_sequencer_crc32_top #(
    parameter int FIFO_DEPTH = fus_pkg::FIFO_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // input frames
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [63:0]  s_axis_tdata,   // [31:0] frame_low, [63:32] frame_high
    input  logic         s_axis_tuser,   // [0] rx_ok
    // results
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [135:0] m_axis_tdata,   // [2:0] action, [34:3] flash_addr,
                                         // [66:35] word_low, [98:67] word_high,
                                         // [100:99] response_code,
                                         // [116:101] boot_flag,
                                         // [132:117] app_status, rest zero
    output logic         m_axis_tlast,
    // configuration writes
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_addr,
    input  logic [31:0]  i_cfg_wdata
);
    import fus_pkg::*;

    logic [7:0]  r_start_cmd;
    logic [31:0] r_app_start;
    logic [31:0] r_app_end;
    logic [31:0] r_app_region;

    logic        w_push;
    t_cmd        w_cmd;
    t_crc_ctl    w_crc_ctl;
    logic        w_crc_busy;
    logic [31:0] w_crc;
    logic        w_fifo_full;
    logic        w_fifo_empty;
    t_cmd        w_head;
    logic        w_pop;
    t_result     w_result;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_cmd  <= RST_START_CMD;
            r_app_start  <= RST_APP_START;
            r_app_end    <= RST_APP_END;
            r_app_region <= RST_APP_REGION;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_START_CMD: r_start_cmd  <= i_cfg_wdata[7:0];
                CFG_APP_START: r_app_start  <= i_cfg_wdata;
                CFG_APP_END:   r_app_end    <= i_cfg_wdata;
                default:       r_app_region <= i_cfg_wdata;
            endcase
        end
    end

    fus_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_ok         (s_axis_tuser),
        .i_lo         (s_axis_tdata[31:0]),
        .i_hi         (s_axis_tdata[63:32]),
        .i_start_cmd  (r_start_cmd),
        .i_app_start  (r_app_start),
        .i_app_end    (r_app_end),
        .i_app_region (r_app_region),
        .i_fifo_full  (w_fifo_full),
        .i_crc_busy   (w_crc_busy),
        .i_crc        (w_crc),
        .o_push       (w_push),
        .o_cmd        (w_cmd),
        .o_crc_ctl    (w_crc_ctl)
    );

    fus_crc u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_crc_ctl),
        .i_data  (s_axis_tdata),
        .o_busy  (w_crc_busy),
        .o_crc   (w_crc)
    );

    fus_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd),
        .i_pop   (w_pop),
        .o_full  (w_fifo_full),
        .o_empty (w_fifo_empty),
        .o_head  (w_head)
    );

    fus_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (w_fifo_empty),
        .i_head   (w_head),
        .o_pop    (w_pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (w_result),
        .o_last   (m_axis_tlast)
    );

    // result packing, first field lowest
    assign m_axis_tdata = {3'd0, w_result.app_status, w_result.boot_flag,
                           w_result.response_code, w_result.word_high,
                           w_result.word_low, w_result.flash_addr, w_result.action};

endmodule
